/* rtl/ipbf_pkg.sv */
// Shared types and constants for the prefix bitmap filter.
package ipbf_pkg;

  localparam int unsigned HOST_BITS = 16;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_CHECK = 1'b1
  } req_type_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] client_id;
    logic [31:0] address;
    logic [5:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic status;
  } out_item_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_CLEAR,
    BE_RMW_RD,
    BE_RMW_WR,
    BE_CHK_RD,
    BE_CHK_WT,
    BE_DONE
  } be_state_t;

endpackage

/* rtl/ipbf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module ipbf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ipbf_front.sv */
// Front end: key search, entry allocation and command build for the back end.
module ipbf_front #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned ENTRY_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipbf_pkg::in_item_t    in_item,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output logic                  cmd_check,
  output logic                  cmd_alloc,
  output logic                  cmd_full,
  output logic                  cmd_hit,
  output logic [ENTRY_W-1:0]    cmd_entry,
  output logic [15:0]           cmd_host,
  output logic [16:0]           cmd_end
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [TABLE_ENTRIES-1:0] key_valid;
  logic [31:0]              key_tag [TABLE_ENTRIES];
  logic [CNT_W-1:0]         used_entries;

  ipbf_pkg::in_item_t       item;
  logic                     busy;
  logic [ENTRY_W:0]         scan;
  logic                     found;
  logic [ENTRY_W-1:0]       found_idx;

  logic                     scan_done;
  logic                     cur_match;
  logic [5:0]               plen;
  logic [16:0]              span;
  logic [16:0]              end_raw;
  logic                     is_check;
  logic                     full;
  logic                     is_new;

  assign in_ready  = !busy && !cmd_valid;
  assign scan_done = (scan == (ENTRY_W+1)'(TABLE_ENTRIES));
  assign cur_match = !scan_done && key_valid[scan[ENTRY_W-1:0]] &&
                     (key_tag[scan[ENTRY_W-1:0]] == {item.client_id, item.address[31:16]});
  assign is_check  = (item.req_type == ipbf_pkg::REQ_CHECK);
  assign full      = (used_entries >= CNT_W'(TABLE_ENTRIES));
  assign is_new    = !is_check && !found;

  // Clamp the prefix and compute the exclusive end of the host range
  always_comb begin
    plen = (item.prefix_len < 6'd16) ? 6'd16 : item.prefix_len;
    span = (plen > 6'd32) ? 17'd0 : (17'd1 << (6'd32 - plen));
    end_raw = {1'b0, item.address[15:0]} + span;
    if (end_raw > 17'h10000) begin
      end_raw = 17'h10000;
    end
  end

  // Search the key table one entry a cycle, then issue a command
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cmd_valid    <= 1'b0;
      key_valid    <= '0;
      used_entries <= '0;
      scan         <= '0;
      found        <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        item  <= in_item;
        busy  <= 1'b1;
        scan  <= '0;
        found <= 1'b0;
      end else if (busy) begin
        if (!scan_done && !found) begin
          if (cur_match) begin
            found     <= 1'b1;
            found_idx <= scan[ENTRY_W-1:0];
          end
          scan <= scan + 1'b1;
        end else begin
          busy      <= 1'b0;
          cmd_valid <= 1'b1;
          cmd_check <= is_check;
          cmd_hit   <= found;
          cmd_host  <= item.address[15:0];
          cmd_end   <= end_raw;
          cmd_alloc <= is_new && !full;
          cmd_full  <= is_new && full;
          cmd_entry <= is_new ? used_entries[ENTRY_W-1:0] : found_idx;
          // Allocate the next free entry for a new key
          if (is_new && !full) begin
            key_valid[used_entries[ENTRY_W-1:0]] <= 1'b1;
            key_tag[used_entries[ENTRY_W-1:0]]   <=
              {item.client_id, item.address[31:16]};
            used_entries <= used_entries + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/ipbf_back.sv */
// Back end: bitmap clear, range set by read-modify-write and bit check.
module ipbf_back #(
  parameter int unsigned ENTRY_W   = 4,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 cmd_check,
  input  logic                 cmd_alloc,
  input  logic                 cmd_full,
  input  logic                 cmd_hit,
  input  logic [ENTRY_W-1:0]   cmd_entry,
  input  logic [15:0]          cmd_host,
  input  logic [16:0]          cmd_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipbf_pkg::out_item_t  out_item
);

  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W = ipbf_pkg::HOST_BITS - BIT_W;
  localparam int unsigned ADDR_W = ENTRY_W + WIDX_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  ipbf_pkg::be_state_t state, state_next;

  logic              check;
  logic              full;
  logic              hit;
  logic [ENTRY_W-1:0] entry;
  logic [16:0]       host_lo;
  logic [16:0]       host_end;
  logic [WIDX_W:0]   widx;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata, mask;
  logic [16:0]       wbase;

  assign cmd_ready = (state == ipbf_pkg::BE_IDLE) && !out_valid;

  ipbf_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Mask of bits in the current word inside [host_lo, host_end)
  always_comb begin
    wbase = 17'(widx[WIDX_W-1:0]) << BIT_W;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ((wbase + 17'(b)) >= host_lo) && ((wbase + 17'(b)) < host_end);
    end
  end

  // Sequence clear, set and check operations
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = {entry, widx[WIDX_W-1:0]};
    wdata = rdata | mask;
    raddr = {entry, widx[WIDX_W-1:0]};
    unique case (state)
      ipbf_pkg::BE_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          if (cmd_check) begin
            state_next = cmd_hit ? ipbf_pkg::BE_CHK_RD : ipbf_pkg::BE_DONE;
          end else if (cmd_full) begin
            state_next = ipbf_pkg::BE_DONE;
          end else if (cmd_alloc) begin
            state_next = ipbf_pkg::BE_CLEAR;
          end else begin
            state_next = ipbf_pkg::BE_RMW_RD;
          end
        end
      end
      ipbf_pkg::BE_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (widx[WIDX_W]) begin
          we = 1'b0;
          state_next = ipbf_pkg::BE_RMW_RD;
        end
      end
      ipbf_pkg::BE_RMW_RD: begin
        if ((wbase >= host_end) || widx[WIDX_W]) begin
          state_next = ipbf_pkg::BE_DONE;
        end else begin
          state_next = ipbf_pkg::BE_RMW_WR;
        end
      end
      ipbf_pkg::BE_RMW_WR: begin
        we = 1'b1;
        state_next = ipbf_pkg::BE_RMW_RD;
      end
      ipbf_pkg::BE_CHK_RD: state_next = ipbf_pkg::BE_CHK_WT;
      ipbf_pkg::BE_CHK_WT: state_next = ipbf_pkg::BE_DONE;
      ipbf_pkg::BE_DONE:   state_next = ipbf_pkg::BE_IDLE;
      default:             state_next = ipbf_pkg::BE_IDLE;
    endcase
  end

  // State, command hold, word walk and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipbf_pkg::BE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ipbf_pkg::BE_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            check    <= cmd_check;
            full     <= cmd_full;
            hit      <= cmd_hit;
            entry    <= cmd_entry;
            host_lo  <= {1'b0, cmd_host};
            host_end <= cmd_end;
            widx     <= cmd_alloc ? '0 : (WIDX_W+1)'(cmd_host[15:BIT_W]);
          end
        end
        ipbf_pkg::BE_CLEAR: begin
          widx <= widx[WIDX_W] ? (WIDX_W+1)'(host_lo[15:BIT_W]) : widx + 1'b1;
        end
        ipbf_pkg::BE_RMW_WR: widx <= widx + 1'b1;
        ipbf_pkg::BE_CHK_WT: hit <= rdata[host_lo[BIT_W-1:0]];
        ipbf_pkg::BE_DONE: begin
          out_valid <= 1'b1;
          out_item.status <= (!check && full) ? ipbf_pkg::STATUS_FULL
                                              : ipbf_pkg::STATUS_OK;
          out_item.inside_res <= check ? hit : !full;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ip_prefix_bitmap_filter_core.sv */
// Per-client IPv4 address set kept as host bitmaps per 16-bit prefix.
// One request at a time through each side. The front end searches the key
// table one entry per clock, stopping early on a match, and hands a command
// over a one-deep register to the back end, which owns the bitmap RAM. A check
// of a known key reads its word and registers the addressed bit. An add walks
// the covered bitmap words with a read and a write each; allocating a new
// entry first clears its whole bitmap. No reset clearing pass.
module ip_prefix_bitmap_filter_core #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned WORD_BITS     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipbf_pkg::out_item_t out_data
);

  localparam int unsigned ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic               cmd_valid, cmd_ready;
  logic               cmd_check, cmd_alloc, cmd_full, cmd_hit;
  logic [ENTRY_W-1:0] cmd_entry;
  logic [15:0]        cmd_host;
  logic [16:0]        cmd_end;

  ipbf_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .ENTRY_W(ENTRY_W)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item(in_data),
    .cmd_valid, .cmd_ready, .cmd_check, .cmd_alloc, .cmd_full, .cmd_hit,
    .cmd_entry, .cmd_host, .cmd_end
  );

  ipbf_back #(.ENTRY_W(ENTRY_W), .WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd_check, .cmd_alloc, .cmd_full,
    .cmd_hit, .cmd_entry, .cmd_host, .cmd_end,
    .out_valid, .out_ready, .out_item(out_data)
  );

endmodule

/* rtl/ipbf_checker.sv */
// Port-level assertions for the prefix bitmap filter, bound to the top level.
module ipbf_assertions (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ipbf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ipbf_pkg::out_item_t out_data
);

  // A full status never comes with a positive result
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> !out_data.inside_res)
    else $error("full status with positive result");

  // No new request accepted in the cycle right after one
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  // Nothing is valid right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind ip_prefix_bitmap_filter_core ipbf_assertions u_ipbf_assertions (.*);

/* bench/ipbf_checker.sv */
// Channel monitor, result predictor and scoreboard for the prefix bitmap filter.
`timescale 1ns / 100ps
module ipbf_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ipbf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ipbf_pkg::out_item_t out_data,
  output int                  errors,
  output int                  pending,
  output int                  hit_count,
  output int                  full_count
);

  localparam int unsigned N_KEYS  = 16;
  localparam int unsigned N_WORDS = 1024;

  // predicted state: key table and host bitmaps
  bit          key_ok [N_KEYS];
  logic [15:0] key_client [N_KEYS];
  logic [15:0] key_upper [N_KEYS];
  int          keys_used;
  bit   [63:0] host_map [N_KEYS][N_WORDS];

  ipbf_pkg::out_item_t result_q[$];

  initial begin
    errors     = 0;
    hit_count  = 0;
    full_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // work out the result of one request and update the predicted state
  task automatic predict_filter(input ipbf_pkg::in_item_t it,
                                output ipbf_pkg::out_item_t res);
    int          slot;
    int unsigned host;
    int unsigned last;
    int unsigned plen;
    slot = -1;
    host = it.address[15:0];
    for (int k = 0; k < N_KEYS; k++) begin
      if (slot < 0 && key_ok[k] && key_client[k] == it.client_id &&
          key_upper[k] == it.address[31:16]) begin
        slot = k;
      end
    end
    res.status = ipbf_pkg::STATUS_OK;
    if (it.req_type == ipbf_pkg::REQ_CHECK) begin
      res.inside_res = (slot < 0) ? 1'b0 : host_map[slot][host >> 6][host & 63];
      return;
    end
    if (slot < 0) begin
      if (keys_used >= N_KEYS) begin
        res.inside_res = 1'b0;
        res.status     = ipbf_pkg::STATUS_FULL;
        return;
      end
      slot = keys_used;
      keys_used++;
      key_ok[slot]     = 1'b1;
      key_client[slot] = it.client_id;
      key_upper[slot]  = it.address[31:16];
      for (int w = 0; w < N_WORDS; w++) host_map[slot][w] = '0;
    end
    // short prefixes cover from the host to the end of the bitmap, long ones nothing
    plen = (it.prefix_len < 16) ? 16 : it.prefix_len;
    last = (plen > 32) ? host : host + (1 << (32 - plen));
    if (last > 65536) last = 65536;
    for (int unsigned h = host; h < last; h++) host_map[slot][h >> 6][h & 63] = 1'b1;
    res.inside_res = 1'b1;
  endtask

  // compare results, then predict newly accepted requests
  always @(posedge clk) begin
    ipbf_pkg::out_item_t want;
    ipbf_pkg::out_item_t got;
    if (rst) begin
      for (int k = 0; k < N_KEYS; k++) key_ok[k] = 1'b0;
      keys_used = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (out_data.inside_res !== want.inside_res)
            report_mismatch($sformatf("inside_res %b, expected %b",
                                      out_data.inside_res, want.inside_res));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b",
                                      out_data.status, want.status));
          if (want.status == ipbf_pkg::STATUS_FULL) full_count++;
          if (want.inside_res && out_data.inside_res) hit_count++;
        end
      end
      if (in_valid && in_ready) begin
        predict_filter(in_data, got);
        result_q.push_back(got);
      end
    end
    pending = result_q.size();
  end

endmodule

/* bench/tb.sv */
// Top of the prefix bitmap filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int N_RANDOM = 480;
  localparam int N_QUIET  = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ipbf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ipbf_pkg::out_item_t out_data;

  int errors, pending, hit_count, full_count;
  int sent = 0;
  bit quiet = 1'b0;
  logic [31:0] key_pool [12];
  logic [15:0] pool_client [12];
  logic [31:0] last_add;

  always #10 clk = ~clk;

  ip_prefix_bitmap_filter_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ipbf_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .hit_count(hit_count), .full_count(full_count)
  );

  // offer one request, hold it until accepted, maybe idle afterwards
  task automatic send_request(input ipbf_pkg::req_type_t kind, input logic [15:0] client,
                              input logic [31:0] addr, input logic [5:0] plen);
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, client_id: client, address: addr, prefix_len: plen};
    do @(posedge clk); while (!in_ready);
    sent++;
    if (kind == ipbf_pkg::REQ_ADD) last_add = addr;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sent >= 150 && sent < 160) begin
        out_ready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
        out_ready <= 1'b1;
        wait (sent >= 160);
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("[ip_prefix_bitmap_filter_core] ERROR");
    $finish;
  end

  initial begin
    int          idx;
    logic [15:0] client;
    logic [31:0] addr;
    logic [5:0]  plen;
    for (int k = 0; k < 12; k++) begin
      key_pool[k]    = $urandom;
      pool_client[k] = $urandom;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: missing key, single host, range past end, short and long prefixes
    send_request(ipbf_pkg::REQ_CHECK, 16'h0001, 32'h0A00_0005, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'h0001, 32'h0A00_0005, 6'd32);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0001, 32'h0A00_0005, 6'd0);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0001, 32'h0A00_0006, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'h0001, 32'h0A00_FFF0, 6'd24);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0001, 32'h0A00_FFFF, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'h0002, 32'h0B00_1234, 6'd8);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0002, 32'h0B00_1233, 6'd0);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0002, 32'h0B00_1234, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'h0003, 32'h0C00_0100, 6'd33);
    send_request(ipbf_pkg::REQ_ADD,   16'h0003, 32'h0C00_0200, 6'd63);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0003, 32'h0C00_0100, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'h0004, 32'h0D00_0000, 6'd16);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0004, 32'h0D00_FFFF, 6'd0);
    send_request(ipbf_pkg::REQ_ADD,   16'hFFFF, 32'hFFFF_FFFF, 6'd0);
    send_request(ipbf_pkg::REQ_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    send_request(ipbf_pkg::REQ_ADD,   16'h0000, 32'h0000_0000, 6'd32);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0000, 32'h0000_0001, 6'd0);
    send_request(ipbf_pkg::REQ_CHECK, 16'h0001, 32'h0B00_0005, 6'd0);

    // random: mostly pooled keys so entries are reused, fresh keys fill the table
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      idx = $urandom_range(0, 11);
      if ($urandom_range(0, 99) < 15) begin
        client = $urandom;
        addr   = $urandom;
      end else begin
        client = pool_client[idx];
        addr   = {key_pool[idx][31:16], 16'($urandom)};
      end
      case ($urandom_range(0, 19))
        0:       plen = $urandom_range(0, 15);
        1:       plen = $urandom_range(33, 63);
        default: plen = $urandom_range(22, 32);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        send_request(ipbf_pkg::REQ_ADD, client, addr, plen);
      end else if ($urandom_range(0, 1) == 0) begin
        send_request(ipbf_pkg::REQ_CHECK, client, last_add + $urandom_range(0, 3) - 1, plen);
      end else begin
        send_request(ipbf_pkg::REQ_CHECK, client, addr, plen);
      end
    end
    in_valid <= 1'b0;

    // let the last request reach the scoreboard, drain, then settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d requests: %0d set-bit results, %0d table-full results.",
             sent, hit_count, full_count);
    if (errors == 0 && pending == 0) begin
      $display("[ip_prefix_bitmap_filter_core] OK");
    end else begin
      $display("[ip_prefix_bitmap_filter_core] ERROR");
    end
    $finish;
  end

endmodule
